>>> rtl/core/gcw_pkg.sv
// shared constants, types and table-building functions for the contact width to joint angle block
`default_nettype none
package gcw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH_LIMIT  = 2'd0,
    CFG_EMPTY_FRAME_WIDTH = 2'd1,
    CFG_EMA_WEIGHT        = 2'd2
  } cfg_index_t;

  localparam logic [18:0] HALF_WIDTH_RST  = 19'd11000;
  localparam logic [19:0] EMPTY_WIDTH_RST = 20'd85000;
  localparam logic [16:0] EMA_WEIGHT_RST  = 17'd65536;

  localparam logic [16:0] STROKE_UM  = 17'd85000;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [15:0] HALF_Q16   = 16'd32768;
  localparam logic [15:0] ANGLE_MAX  = 16'd52429;

  // divider by the stroke: dividend and remainder widths
  localparam int DIV_W   = 33;
  localparam int REM_W   = 17;
  // stroke is 8 * 10625: quotient = ((n >> 3) * STROKE_RECIP) >> RECIP_SHIFT, exact below 2^33
  localparam int          STROKE_SHIFT = 3;
  localparam int          RECIP_SHIFT  = 44;
  localparam logic [30:0] STROKE_RECIP = 31'd1655735158;

  localparam longint          COS_A_Q30 = 64'sd698051792;
  localparam longint          COS_B_Q30 = 64'sd100301722;
  localparam longint unsigned ALPHA_Q30 = 64'd926709321;

  // truncated taylor cosine in q2.30
  function automatic longint cos_q30(longint unsigned th);
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    t2   = (th * th) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * t2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd90;  sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd132; sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd182; sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd240; sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd306; sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd380; sum = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd462; sum = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd552; sum = sum + longint'(term);
    return sum;
  endfunction

  // smallest angle whose cosine after alpha drops to u, by bisection
  function automatic logic [15:0] angle_for_u(longint u);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'(ANGLE_MAX);
    for (int s = 0; s < 17; s++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (cos_q30(ALPHA_Q30 + (mid << 14)) <= u) begin
          hi = mid;
        end else begin
          lo = mid + 64'd1;
        end
      end
    end
    return lo[15:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/gcw_angle_rom.sv
// constant interpolation table of joint angle against contact width
`default_nettype none
module gcw_angle_rom #(
  parameter int DEPTH = 256
) (
  input  wire logic [$clog2(DEPTH+1)-1:0] idx,
  output logic [15:0]                     angle
);

  localparam int     IW    = $clog2(DEPTH + 1);
  localparam longint SLOPE = gcw_pkg::COS_A_Q30 + gcw_pkg::COS_B_Q30;

  logic [15:0] tbl [DEPTH+1];

  for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
    localparam longint UQ =
      (SLOPE * longint'(g) + longint'(DEPTH / 2)) / longint'(DEPTH) - gcw_pkg::COS_B_Q30;
    localparam logic [15:0] ENTRY = gcw_pkg::angle_for_u(UQ);
    assign tbl[g] = ENTRY;
  end

  always_comb begin
    if (idx <= IW'(DEPTH)) begin
      angle = tbl[idx];
    end else begin
      angle = '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/gcw_stroke_div.sv
// reciprocal-multiply divider by the gripper stroke
`default_nettype none
module gcw_stroke_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [gcw_pkg::DIV_W-1:0]    dividend,
  output logic                              done,
  output logic [gcw_pkg::DIV_W-1:0]         quot,
  output logic [gcw_pkg::REM_W-1:0]         rem
);

  localparam int DW = gcw_pkg::DIV_W;
  localparam int RW = gcw_pkg::REM_W;
  localparam int SH = gcw_pkg::STROKE_SHIFT;
  localparam int XW = DW - SH;
  localparam int YW = $bits(gcw_pkg::STROKE_RECIP);
  localparam int PW = XW + YW;
  localparam int QW = PW - gcw_pkg::RECIP_SHIFT;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RECIP,
    D_BACK
  } div_state_t;

  div_state_t    state_r, state_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] num_r, num_nxt;
  logic [DW-1:0] quot_r, quot_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [XW-1:0] mul_x;
  logic [YW-1:0] mul_y;
  logic [PW-1:0] prod;
  logic [DW-1:0] back;

  // one multiplier: reciprocal estimate, then quotient times stroke
  assign prod = PW'(mul_x) * PW'(mul_y);
  assign back = num_r - prod[DW-1:0];

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    num_nxt   = num_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    mul_x     = num_r[DW-1:SH];
    mul_y     = gcw_pkg::STROKE_RECIP;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          num_nxt   = dividend;
          state_nxt = D_RECIP;
        end
      end
      D_RECIP: begin
        quot_nxt  = DW'(prod[PW-1:gcw_pkg::RECIP_SHIFT]);
        state_nxt = D_BACK;
      end
      D_BACK: begin
        mul_x     = XW'(quot_r[QW-1:0]);
        mul_y     = YW'(gcw_pkg::STROKE_UM);
        rem_nxt   = back[RW-1:0];
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/core/gripper_contact_width_to_joint_angle_top.sv
// top level: frame width tracking, moving average and width to joint angle mapping
//
// Input channel (in_valid/in_stall) carries one proximity point per transfer,
// with in_frame_end marking the last item of a frame. A point-only item leaves
// in_stall low. A frame-end item closes the frame and runs the result sequence
// on one shared multiplier and one reciprocal divider by the stroke (a multiply
// and a multiply-back per division): two divisions, or none when the smoothed
// width lies beyond the stroke. in_stall is high for the whole sequence.
// Output channel (out_valid/out_stall) delivers one result per frame end from
// an output register; new points are taken while a result waits there, and a
// following frame end parks in its final step until that register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them while the block is idle (not enforced); an unknown index is ignored.
// Reset (rst_n, synchronous) restores register defaults, clears the running
// maximum and sets the filtered width to the 85000 um stroke.
`default_nettype none
module gripper_contact_width_to_joint_angle_top #(
  parameter int COORD_BITS       = 20,
  parameter int ACOS_TABLE_DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [COORD_BITS-1:0]       in_point_x,
  input  wire logic signed [COORD_BITS-1:0]       in_point_y,
  input  wire logic                               in_point_valid,
  input  wire logic                               in_frame_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [15:0]                             out_joint_angle,
  output logic [19:0]                             out_smoothed_width,
  input  wire logic                               cfg_we,
  input  wire logic [gcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int FW = (COORD_BITS + 1 > 20) ? COORD_BITS + 1 : 20;
  localparam int MW = FW + 17;
  localparam int IW = $clog2(ACOS_TABLE_DEPTH + 1);
  localparam int DW = gcw_pkg::DIV_W;
  localparam logic [16:0] DEPTH_B = 17'(ACOS_TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NEW,
    S_MUL_OLD,
    S_ROUND,
    S_POS,
    S_DIV_POS,
    S_RD_A,
    S_RD_B,
    S_MUL_DIFF,
    S_DIV_DIFF,
    S_PUSH
  } state_t;

  state_t        state_r, state_nxt;
  logic [18:0]   hwl_r, hwl_nxt;
  logic [19:0]   efw_r, efw_nxt;
  logic [16:0]   ema_r, ema_nxt;
  logic [CB-1:0] max_abs_x_r, max_abs_x_nxt;
  logic          any_seen_r, any_seen_nxt;
  logic [FW-1:0] filtered_r, filtered_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [FW-1:0] width_r, width_nxt;
  logic [MW-1:0] acc_r, acc_nxt;
  logic [16:0]   frac_r, frac_nxt;
  logic [IW-1:0] tbl_idx_r, tbl_idx_nxt;
  logic [15:0]   a_r, a_nxt;
  logic [15:0]   b_r, b_nxt;
  logic [15:0]   angle_r, angle_nxt;
  logic [15:0]   out_angle_r, out_angle_nxt;
  logic [19:0]   out_width_r, out_width_nxt;

  logic [CB-1:0]      x_raw, y_raw, ax, ay;
  logic               pt_take;
  logic [CB-1:0]      new_max;
  logic               new_any;
  logic [16:0]        w_eff;
  logic [FW-1:0]      mul_a;
  logic [16:0]        mul_b;
  logic [MW-1:0]      prod;
  logic [MW-1:0]      acc_round;
  logic signed [16:0] diff;
  logic [15:0]        diff_mag;
  logic [16:0]        angle_sum;
  logic [CB-1:0]      sat;
  logic [CB+19:0]     sat_ext;
  logic               out_free;

  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic               div_done;
  logic [DW-1:0]      div_quot;
  logic [gcw_pkg::REM_W-1:0] div_rem;
  logic [15:0]        rom_angle;

  gcw_stroke_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  gcw_angle_rom #(
    .DEPTH (ACOS_TABLE_DEPTH)
  ) u_rom (
    .idx   (tbl_idx_r),
    .angle (rom_angle)
  );

  // shared multiplier
  assign prod = MW'(mul_a) * MW'(mul_b);

  always_comb begin
    x_raw   = in_point_x;
    y_raw   = in_point_y;
    ax      = x_raw[CB-1] ? CB'(~x_raw + 1'b1) : x_raw;
    ay      = y_raw[CB-1] ? CB'(~y_raw + 1'b1) : y_raw;
    pt_take = in_point_valid && (FW'(ay) < FW'(hwl_r)) && (ax > max_abs_x_r);
    new_max = pt_take ? ax : max_abs_x_r;
    new_any = any_seen_r || in_point_valid;
    w_eff   = (ema_r > gcw_pkg::ONE_Q16) ? gcw_pkg::ONE_Q16 : ema_r;

    acc_round = acc_r + MW'(gcw_pkg::HALF_Q16);
    diff      = $signed({1'b0, b_r}) - $signed({1'b0, a_r});
    diff_mag  = diff[16] ? 16'(-diff) : diff[15:0];
    angle_sum = diff[16] ? ({1'b0, a_r} - div_quot[16:0]) : ({1'b0, a_r} + div_quot[16:0]);

    sat      = (filtered_r > FW'({CB{1'b1}})) ? {CB{1'b1}} : filtered_r[CB-1:0];
    sat_ext  = {20'd0, sat};
    out_free = !out_valid_r || !out_stall;

    state_nxt     = state_r;
    hwl_nxt       = hwl_r;
    efw_nxt       = efw_r;
    ema_nxt       = ema_r;
    max_abs_x_nxt = max_abs_x_r;
    any_seen_nxt  = any_seen_r;
    filtered_nxt  = filtered_r;
    out_valid_nxt = out_valid_r;
    width_nxt     = width_r;
    acc_nxt       = acc_r;
    frac_nxt      = frac_r;
    tbl_idx_nxt   = tbl_idx_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    angle_nxt     = angle_r;
    out_angle_nxt = out_angle_r;
    out_width_nxt = out_width_r;
    mul_a         = filtered_r;
    mul_b         = DEPTH_B;
    div_start     = 1'b0;
    div_dividend  = prod[DW-1:0];

    if (cfg_we) begin
      case (cfg_index)
        gcw_pkg::CFG_HALF_WIDTH_LIMIT:  hwl_nxt = cfg_data[18:0];
        gcw_pkg::CFG_EMPTY_FRAME_WIDTH: efw_nxt = cfg_data[19:0];
        gcw_pkg::CFG_EMA_WEIGHT:        ema_nxt = cfg_data[16:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_frame_end) begin
            width_nxt     = new_any ? FW'({new_max, 1'b0}) : FW'(efw_r);
            max_abs_x_nxt = '0;
            any_seen_nxt  = 1'b0;
            state_nxt     = S_MUL_NEW;
          end else begin
            max_abs_x_nxt = new_max;
            any_seen_nxt  = new_any;
          end
        end
      end
      S_MUL_NEW: begin
        mul_a     = width_r;
        mul_b     = w_eff;
        acc_nxt   = prod;
        state_nxt = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        mul_a     = filtered_r;
        mul_b     = gcw_pkg::ONE_Q16 - w_eff;
        acc_nxt   = acc_r + prod;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        filtered_nxt = acc_round[FW+15:16];
        state_nxt    = S_POS;
      end
      S_POS: begin
        // width beyond the stroke maps to a zero angle
        if (filtered_r > FW'(gcw_pkg::STROKE_UM)) begin
          angle_nxt = '0;
          state_nxt = S_PUSH;
        end else begin
          mul_a     = filtered_r;
          mul_b     = DEPTH_B;
          div_start = 1'b1;
          state_nxt = S_DIV_POS;
        end
      end
      S_DIV_POS: begin
        if (div_done) begin
          tbl_idx_nxt = div_quot[IW-1:0];
          frac_nxt    = div_rem;
          state_nxt   = S_RD_A;
        end
      end
      S_RD_A: begin
        a_nxt       = rom_angle;
        tbl_idx_nxt = tbl_idx_r + IW'(1);
        state_nxt   = S_RD_B;
      end
      S_RD_B: begin
        b_nxt     = rom_angle;
        state_nxt = S_MUL_DIFF;
      end
      S_MUL_DIFF: begin
        mul_a     = FW'(diff_mag);
        mul_b     = frac_r;
        div_start = 1'b1;
        state_nxt = S_DIV_DIFF;
      end
      S_DIV_DIFF: begin
        if (div_done) begin
          angle_nxt = angle_sum[15:0];
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = angle_r;
          out_width_nxt = sat_ext[19:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hwl_r       <= gcw_pkg::HALF_WIDTH_RST;
      efw_r       <= gcw_pkg::EMPTY_WIDTH_RST;
      ema_r       <= gcw_pkg::EMA_WEIGHT_RST;
      max_abs_x_r <= '0;
      any_seen_r  <= 1'b0;
      filtered_r  <= FW'(gcw_pkg::STROKE_UM);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hwl_r       <= hwl_nxt;
      efw_r       <= efw_nxt;
      ema_r       <= ema_nxt;
      max_abs_x_r <= max_abs_x_nxt;
      any_seen_r  <= any_seen_nxt;
      filtered_r  <= filtered_nxt;
      out_valid_r <= out_valid_nxt;
    end
    width_r     <= width_nxt;
    acc_r       <= acc_nxt;
    frac_r      <= frac_nxt;
    tbl_idx_r   <= tbl_idx_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    angle_r     <= angle_nxt;
    out_angle_r <= out_angle_nxt;
    out_width_r <= out_width_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_joint_angle    = out_angle_r;
  assign out_smoothed_width = out_width_r;

endmodule
`default_nettype wire
